@@ design/kwm_pkg.sv @@
package kwm_pkg;

  localparam int LISTS       = 8;
  localparam int LIST_DEPTH  = 64;
  localparam int VALUE_BITS  = 32;
  localparam int ID_BITS     = 3;
  localparam int LIST_W      = $clog2(LISTS);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int SLOT_W      = $clog2(LIST_DEPTH);
  localparam int STORE_DEPTH = LISTS * LIST_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TREE_LV     = LIST_W;
  localparam int TREE_N      = 1 << LIST_W;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [LIST_W-1:0]            lidx_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_EXEC,
    S_REFILL
  } state_t;

  typedef struct packed {
    logic capture;
    logic pick;
    logic exec;
    logic refill;
  } dp_ctrl_t;

  typedef struct packed {
    logic refill;
  } dp_sts_t;

  function automatic addr_t slot_addr(lidx_t l, cnt_t s);
    return addr_t'(ADDR_W'(l) * ADDR_W'(LIST_DEPTH)) + addr_t'(s[SLOT_W-1:0]);
  endfunction

endpackage

@@ design/kwm_cmd_if.sv @@
interface kwm_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           cmd;
  logic [kwm_pkg::ID_BITS-1:0]          list_id;
  logic signed [kwm_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, cmd, list_id, value, input ready);
  modport sink (input valid, cmd, list_id, value, output ready);
endinterface

@@ design/kwm_res_if.sv @@
interface kwm_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic signed [kwm_pkg::VALUE_BITS-1:0] out_value;
  logic [kwm_pkg::ID_BITS-1:0]          source_list;
  logic                                 final_element;

  modport source (output valid, status, out_value, source_list, final_element, input ready);
  modport sink (input valid, status, out_value, source_list, final_element, output ready);
endinterface

@@ design/kwm_ram.sv @@
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/kwm_ctrl.sv @@
module kwm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kwm_pkg::dp_sts_t  sts,
  output kwm_pkg::dp_ctrl_t ctrl
);

  kwm_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kwm_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    ctrl           = '0;
    case (state)
      kwm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next   = kwm_pkg::S_PICK;
        end
      end
      kwm_pkg::S_PICK: begin
        ctrl.pick  = 1'b1;
        state_next = kwm_pkg::S_EXEC;
      end
      kwm_pkg::S_EXEC: begin
        // result register must be free before the command commits
        if (!out_valid || out_ready) begin
          ctrl.exec      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = sts.refill ? kwm_pkg::S_REFILL : kwm_pkg::S_IDLE;
        end
      end
      kwm_pkg::S_REFILL: begin
        ctrl.refill = 1'b1;
        state_next  = kwm_pkg::S_IDLE;
      end
      default: begin
        state_next = kwm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ design/kwm_dp.sv @@
module kwm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kwm_pkg::dp_ctrl_t             ctrl,
  output kwm_pkg::dp_sts_t              sts,
  input  logic [1:0]                    in_cmd,
  input  logic [kwm_pkg::ID_BITS-1:0]   in_list_id,
  input  kwm_pkg::value_t               in_value,
  output logic [1:0]                    status,
  output kwm_pkg::value_t               out_value,
  output logic [kwm_pkg::ID_BITS-1:0]   source_list,
  output logic                          final_element
);

  logic [1:0]                  req_cmd;
  logic [kwm_pkg::ID_BITS-1:0] req_id;
  kwm_pkg::value_t             req_value;

  kwm_pkg::cnt_t   rp   [kwm_pkg::LISTS];
  kwm_pkg::cnt_t   wc   [kwm_pkg::LISTS];
  kwm_pkg::value_t last [kwm_pkg::LISTS];
  kwm_pkg::value_t head [kwm_pkg::LISTS];
  logic            hv   [kwm_pkg::LISTS];

  logic            win_found;
  kwm_pkg::lidx_t  win_idx;

  logic            t_found [kwm_pkg::TREE_LV+1][kwm_pkg::TREE_N];
  kwm_pkg::lidx_t  t_idx   [kwm_pkg::TREE_LV+1][kwm_pkg::TREE_N];
  kwm_pkg::value_t t_val   [kwm_pkg::TREE_LV+1][kwm_pkg::TREE_N];

  kwm_pkg::lidx_t  app_idx;
  logic            app_ok_id;
  logic            app_full;
  logic            app_order;
  logic            app_we;
  kwm_pkg::cnt_t   rp_inc;
  logic            refill;
  logic            others;
  kwm_pkg::addr_t  waddr;
  kwm_pkg::addr_t  raddr;
  logic [kwm_pkg::VALUE_BITS-1:0] rdata;

  always_comb begin
    for (int i = 0; i < kwm_pkg::LISTS; i++) begin
      hv[i] = rp[i] < wc[i];
    end
  end

  // min tree over the list heads; right side wins ties
  always_comb begin
    for (int j = 0; j < kwm_pkg::TREE_N; j++) begin
      if (j < kwm_pkg::LISTS) begin
        t_found[0][j] = hv[kwm_pkg::LIST_W'(j)];
        t_val[0][j]   = head[kwm_pkg::LIST_W'(j)];
      end else begin
        t_found[0][j] = 1'b0;
        t_val[0][j]   = '0;
      end
      t_idx[0][j] = kwm_pkg::LIST_W'(j);
    end
    for (int l = 1; l <= kwm_pkg::TREE_LV; l++) begin
      for (int j = 0; j < kwm_pkg::TREE_N; j++) begin
        if (j < (kwm_pkg::TREE_N >> l)) begin
          if (t_found[l-1][2*j+1] &&
              (!t_found[l-1][2*j] || t_val[l-1][2*j+1] <= t_val[l-1][2*j])) begin
            t_found[l][j] = 1'b1;
            t_idx[l][j]   = t_idx[l-1][2*j+1];
            t_val[l][j]   = t_val[l-1][2*j+1];
          end else begin
            t_found[l][j] = t_found[l-1][2*j];
            t_idx[l][j]   = t_idx[l-1][2*j];
            t_val[l][j]   = t_val[l-1][2*j];
          end
        end else begin
          t_found[l][j] = 1'b0;
          t_idx[l][j]   = '0;
          t_val[l][j]   = '0;
        end
      end
    end
  end

  always_comb begin
    app_idx   = kwm_pkg::LIST_W'(req_id);
    app_ok_id = 32'(req_id) < 32'(kwm_pkg::LISTS);
    app_full  = !app_ok_id || (wc[app_idx] >= kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH));
    app_order = (wc[app_idx] != '0) && (req_value < last[app_idx]);
    app_we    = ctrl.exec && (req_cmd == kwm_pkg::CMD_APPEND) && !app_full && !app_order;
    waddr     = kwm_pkg::slot_addr(app_idx, wc[app_idx]);

    rp_inc = rp[win_idx] + kwm_pkg::CNT_W'(1);
    raddr  = kwm_pkg::slot_addr(win_idx, rp_inc);
    refill = (req_cmd == kwm_pkg::CMD_POP) && win_found && (rp_inc < wc[win_idx]);
    others = 1'b0;
    for (int i = 0; i < kwm_pkg::LISTS; i++) begin
      if (kwm_pkg::LIST_W'(i) != win_idx && hv[i]) begin
        others = 1'b1;
      end
    end
    sts.refill = refill;
  end

  kwm_ram #(
    .WIDTH(kwm_pkg::VALUE_BITS),
    .DEPTH(kwm_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (app_we),
    .waddr(waddr),
    .wdata(req_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req_cmd   <= in_cmd;
      req_id    <= in_list_id;
      req_value <= in_value;
    end
    if (ctrl.pick) begin
      win_found <= t_found[kwm_pkg::TREE_LV][0];
      win_idx   <= t_idx[kwm_pkg::TREE_LV][0];
    end
    if (ctrl.refill) begin
      head[win_idx] <= kwm_pkg::value_t'(rdata);
    end
    if (app_we) begin
      last[app_idx] <= req_value;
      if (rp[app_idx] == wc[app_idx]) begin
        head[app_idx] <= req_value;
      end
    end
    if (ctrl.exec) begin
      case (req_cmd)
        kwm_pkg::CMD_APPEND: begin
          if (app_full) begin
            status <= kwm_pkg::ST_FULL;
          end else if (app_order) begin
            status <= kwm_pkg::ST_ORDER;
          end else begin
            status <= kwm_pkg::ST_OK;
          end
          out_value     <= '0;
          source_list   <= '0;
          final_element <= 1'b0;
        end
        kwm_pkg::CMD_POP: begin
          if (!win_found) begin
            status        <= kwm_pkg::ST_EMPTY;
            out_value     <= '0;
            source_list   <= '0;
            final_element <= 1'b0;
          end else begin
            status        <= kwm_pkg::ST_OK;
            out_value     <= head[win_idx];
            source_list   <= kwm_pkg::ID_BITS'(win_idx);
            final_element <= !(others || refill);
          end
        end
        default: begin
          status        <= kwm_pkg::ST_OK;
          out_value     <= '0;
          source_list   <= '0;
          final_element <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kwm_pkg::LISTS; i++) begin
        rp[i] <= '0;
        wc[i] <= '0;
      end
    end else if (ctrl.exec) begin
      case (req_cmd)
        kwm_pkg::CMD_CLEAR: begin
          for (int i = 0; i < kwm_pkg::LISTS; i++) begin
            rp[i] <= '0;
            wc[i] <= '0;
          end
        end
        kwm_pkg::CMD_APPEND: begin
          if (app_we) begin
            wc[app_idx] <= wc[app_idx] + kwm_pkg::CNT_W'(1);
          end
        end
        kwm_pkg::CMD_POP: begin
          if (win_found) begin
            rp[win_idx] <= rp_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/k_way_sorted_merge.sv @@
// k-way sorted merge: LISTS ascending queues of signed values in one element RAM.
// req channel carries one command beat: clear all lists, append value to
// list_id, pop the smallest head (ties go to the highest list), or no-op.
// rsp channel returns exactly one beat per command: status, popped value,
// source list and a flag set when the pop emptied every list.
// A beat is accepted when valid and ready are both high.
// Each list keeps its head in a register; a pop picks the winner through a
// min tree over the heads, then reads the next element of that list from
// the RAM (registered read) to refill the head.
// Steps: accept, pick, execute, and a refill step for a pop that refills a
// head; the rsp beat is valid the cycle after execute. A new command is
// accepted only once the previous one has left these steps.
// req is taken again while a rsp beat waits; if rsp stays stalled, the
// next command holds in the execute step until the output register frees.
// Reset (rst, synchronous) empties all lists and drops any pending rsp
// beat; RAM contents are not cleared and need no clearing pass.
module k_way_sorted_merge (
  input logic      clk,
  input logic      rst,
  kwm_cmd_if.sink  req,
  kwm_res_if.source rsp
);

  kwm_pkg::dp_ctrl_t ctrl;
  kwm_pkg::dp_sts_t  sts;

  kwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .sts      (sts),
    .ctrl     (ctrl)
  );

  kwm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .sts          (sts),
    .in_cmd       (req.cmd),
    .in_list_id   (req.list_id),
    .in_value     (req.value),
    .status       (rsp.status),
    .out_value    (rsp.out_value),
    .source_list  (rsp.source_list),
    .final_element(rsp.final_element)
  );

endmodule
